// File: hdl/bst_pkg.sv
package bst_pkg;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

endpackage

// File: hdl/bst_if.sv
interface bst_in_if;
  logic                               valid;
  logic                               ready;
  logic [bst_pkg::MODE_W-1:0]         mode;
  logic signed [bst_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface bst_out_if;
  logic                         valid;
  logic                         ready;
  logic [bst_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [bst_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output found, output count, input ready);
  modport sink (input valid, input status, input found, input count, output ready);
endinterface

// File: hdl/bst_ram.sv
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/bounded_set_table.sv
// Bounded set of distinct 32-bit values, held packed in insertion order.
// Requests arrive on in_ch (mode, value) and each one gives exactly one
// response on out_ch (status, found, count) under a valid/ready handshake.
// cfg_we with cfg_wdata sets the size limit, which saturates at CAPACITY;
// it should only be written while no request is in progress.
// A request is taken only when the sequencer is idle. Add and check scan the
// store one entry per cycle through the single read port. A delete compacts
// the entries behind the hit while the read stream continues, one entry
// moved per cycle. Requests on an empty set, and unused modes, go straight
// to the response state without a scan.
// The response sits in an output register; a new request is accepted while
// it waits, but the next response is held back until out_ch.ready has taken
// the previous one. Reset empties the set, restores the limit to 16 and
// drops any pending response; the store itself is not cleared.
module bounded_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bst_in_if.sink                      in_ch,
  bst_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [bst_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int XW     = (CW > bst_pkg::CFG_W) ? CW : bst_pkg::CFG_W;
  localparam int CNT_W  = bst_pkg::COUNT_W;
  localparam int VAL_W  = bst_pkg::VALUE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                      state_r, state_nxt;
  bst_pkg::mode_t              mode_r, mode_nxt;
  logic [VAL_W-1:0]            value_r, value_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic [bst_pkg::CFG_W-1:0]   max_r, max_nxt;
  logic [CW-1:0]               scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]               cmp_idx_r, cmp_idx_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  bst_pkg::status_t            res_status_r, res_status_nxt;
  logic                        res_found_r, res_found_nxt;
  logic                        out_valid_r, out_valid_nxt;
  bst_pkg::status_t            out_status_r, out_status_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [CNT_W-1:0]            out_count_r, out_count_nxt;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [VAL_W-1:0]            wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [VAL_W-1:0]            rd_data;

  logic                        in_fire;
  logic                        at_limit;
  logic                        match;
  logic                        last_read;

  bst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ch.ready   = rst_n && (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.count  = out_count_r;

  // The limit in force is min(max_entries, CAPACITY); the set is full when
  // the count has reached either bound.
  assign at_limit  = (XW'(fill_r) >= XW'(max_r)) || (XW'(fill_r) >= XW'(CAPACITY));
  assign match     = rd_pend_r && (rd_data == value_r);
  assign last_read = rd_pend_r && (scan_idx_r == fill_r);
  assign rd_addr   = AW'(scan_idx_r);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    fill_nxt       = fill_r;
    max_nxt        = cfg_we ? cfg_wdata : max_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    rd_pend_nxt    = 1'b0;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = AW'(fill_r);
    wr_data        = value_r;
    rd_en          = 1'b0;

    // Entries are read in order, one per cycle, in both scan and shift.
    if ((state_r == S_SCAN || state_r == S_SHIFT) && (scan_idx_r < fill_r)) begin
      rd_en        = 1'b1;
      rd_pend_nxt  = 1'b1;
      cmp_idx_nxt  = AW'(scan_idx_r);
      scan_idx_nxt = scan_idx_r + CW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt       = bst_pkg::mode_t'(in_ch.mode);
          value_nxt      = in_ch.value;
          scan_idx_nxt   = '0;
          res_status_nxt = bst_pkg::ST_DONE;
          res_found_nxt  = 1'b0;
          state_nxt      = S_RESP;
          case (bst_pkg::mode_t'(in_ch.mode))
            bst_pkg::MODE_ADD: begin
              if (fill_r != '0) begin
                state_nxt = S_SCAN;
              end else if (at_limit) begin
                res_status_nxt = bst_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_data  = in_ch.value;
                fill_nxt = fill_r + CW'(1);
              end
            end
            bst_pkg::MODE_DELETE: begin
              if (fill_r != '0) begin
                state_nxt = S_SCAN;
              end else begin
                res_status_nxt = bst_pkg::ST_EMPTY;
              end
            end
            bst_pkg::MODE_CHECK: begin
              if (fill_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          state_nxt = S_RESP;
          case (mode_r)
            bst_pkg::MODE_ADD:   res_status_nxt = bst_pkg::ST_PRESENT;
            bst_pkg::MODE_CHECK: res_found_nxt  = 1'b1;
            bst_pkg::MODE_DELETE: begin
              // A hit on the last entry needs no compaction.
              if (scan_idx_r == fill_r) begin
                fill_nxt = fill_r - CW'(1);
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end else if (last_read) begin
          state_nxt = S_RESP;
          case (mode_r)
            bst_pkg::MODE_ADD: begin
              if (at_limit) begin
                res_status_nxt = bst_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
            end
            bst_pkg::MODE_DELETE: res_status_nxt = bst_pkg::ST_MISSING;
            default:              res_status_nxt = bst_pkg::ST_DONE;
          endcase
        end
      end
      S_SHIFT: begin
        // Each entry read behind the hit is written one place lower.
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx_r - AW'(1);
          wr_data = rd_data;
        end
        if (last_read) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = CNT_W'(fill_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      max_r       <= bst_pkg::MAX_ENTRIES_RST;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      max_r       <= max_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    value_r      <= value_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// File: hdl/bst_checker.sv
module bst_checker #(
  parameter int CAPACITY = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bst_pkg::STATUS_W-1:0]   out_status,
  input logic                           out_found,
  input logic [bst_pkg::COUNT_W-1:0]    out_count
);

  // A response that has not been taken stays offered, with its status and count unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("response changed or dropped while stalled");

  // Only one request is in progress at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == bst_pkg::ST_DONE)
    else $error("found reported with a status other than done");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY >= 32) || (out_count <= CAPACITY))
    else $error("count beyond capacity");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response offered straight after reset");

endmodule

bind bounded_set_table bst_checker #(
  .CAPACITY (CAPACITY)
) u_bst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_found  (out_ch.found),
  .out_count  (out_ch.count)
);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int SET_CAPACITY    = 16;
  localparam int PHASE_REQUESTS  = 178;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 25;
  localparam int CNT_W           = bst_pkg::COUNT_W;
  localparam int LIMIT_W         = bst_pkg::CFG_W;

  // Mode 3 is not decoded by the block; it should pass through untouched.
  localparam logic [bst_pkg::MODE_W-1:0]  MODE_UNUSED = 2'd3;
  localparam logic [bst_pkg::VALUE_W-1:0] MOST_NEG    = 32'h8000_0000;
  localparam logic [bst_pkg::VALUE_W-1:0] MOST_POS    = 32'h7fff_ffff;
  localparam logic [bst_pkg::VALUE_W-1:0] ALL_ONES    = 32'hffff_ffff;

  typedef struct packed {
    bst_pkg::status_t              status;
    logic                          found;
    logic [bst_pkg::COUNT_W-1:0]   count;
  } set_response_t;

  class membership_scoreboard;
    bit [bst_pkg::VALUE_W-1:0] held_values[$];
    logic [bst_pkg::CFG_W-1:0] size_limit;
    set_response_t             expected_responses[$];
    int                        mismatches;
    int                        status_tally[5];
    int                        peak_count;

    function new();
      size_limit = bst_pkg::MAX_ENTRIES_RST;
      mismatches = 0;
      peak_count = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void set_limit(logic [bst_pkg::CFG_W-1:0] limit);
      size_limit = limit;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    // Applies one accepted request to the mirrored set and queues its response.
    function void note_request(logic [bst_pkg::MODE_W-1:0] mode,
                               logic [bst_pkg::VALUE_W-1:0] value);
      set_response_t resp;
      int pos;
      int limit_in_use;
      resp.status = bst_pkg::ST_DONE;
      resp.found  = 1'b0;
      pos = -1;
      foreach (held_values[i]) begin
        if (pos < 0 && held_values[i] == value) pos = i;
      end
      limit_in_use = (size_limit > SET_CAPACITY) ? SET_CAPACITY : int'(size_limit);
      case (mode)
        bst_pkg::MODE_ADD: begin
          if (pos >= 0) resp.status = bst_pkg::ST_PRESENT;
          else if (held_values.size() >= limit_in_use) resp.status = bst_pkg::ST_FULL;
          else held_values.push_back(value);
        end
        bst_pkg::MODE_DELETE: begin
          if (held_values.size() == 0) resp.status = bst_pkg::ST_EMPTY;
          else if (pos < 0) resp.status = bst_pkg::ST_MISSING;
          else held_values.delete(pos);
        end
        bst_pkg::MODE_CHECK: resp.found = (pos >= 0);
        default: ;
      endcase
      resp.count = CNT_W'(held_values.size());
      if (held_values.size() > peak_count) peak_count = held_values.size();
      expected_responses.push_back(resp);
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_response(logic [bst_pkg::STATUS_W-1:0] status, logic found,
                                 logic [bst_pkg::COUNT_W-1:0] count);
      set_response_t exp;
      if (status < 5) status_tally[status]++;
      if (expected_responses.size() == 0) begin
        note_mismatch($sformatf("response with none outstanding (status %0d found %0d count %0d)",
                                status, found, count));
        return;
      end
      exp = expected_responses.pop_front();
      if (status !== exp.status || found !== exp.found || count !== exp.count)
        note_mismatch($sformatf("expected status %0d found %0d count %0d, got %0d %0d %0d",
                                exp.status, exp.found, exp.count, status, found, count));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bst_pkg::CFG_W-1:0] cfg_wdata;

  bst_in_if  in_ch();
  bst_out_if out_ch();

  bounded_set_table #(.CAPACITY(SET_CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  membership_scoreboard sb = new();

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_request = 1'b0;
  int requests_sent = 0;
  int limit_settings = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic [bst_pkg::MODE_W-1:0] mode,
                              logic [bst_pkg::VALUE_W-1:0] value);
    int gap;
    gap = tx_steady ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(mode, value);
    requests_sent++;
  endtask

  // Stops offering requests and waits until every response has been taken.
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [bst_pkg::CFG_W-1:0] limit);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(limit);
    limit_settings++;
  endtask

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (stall > 0 && !rx_steady) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = 0;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_response(out_ch.status, out_ch.found, out_ch.count);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, sb.pending());
      $display("FAIL bounded_set_table");
      $finish;
    end
  end

  initial begin
    logic [bst_pkg::CFG_W-1:0]   phase_limits[10];
    logic [bst_pkg::VALUE_W-1:0] value_pool[24];
    logic [bst_pkg::MODE_W-1:0]  mode;
    logic [bst_pkg::VALUE_W-1:0] value;
    int add_weight;
    int r;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.mode  = '0;
    in_ch.value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset limit of 16.
    send_request(bst_pkg::MODE_DELETE, 32'd0);
    send_request(bst_pkg::MODE_CHECK, 32'd0);
    send_request(MODE_UNUSED, ALL_ONES);
    send_request(bst_pkg::MODE_ADD, MOST_NEG);
    send_request(bst_pkg::MODE_ADD, MOST_POS);
    send_request(bst_pkg::MODE_ADD, 32'd0);
    send_request(bst_pkg::MODE_ADD, ALL_ONES);
    send_request(bst_pkg::MODE_ADD, MOST_POS);
    send_request(bst_pkg::MODE_CHECK, ALL_ONES);
    send_request(bst_pkg::MODE_CHECK, 32'd1);
    send_request(bst_pkg::MODE_DELETE, 32'd12345);
    send_request(bst_pkg::MODE_DELETE, MOST_NEG);
    send_request(MODE_UNUSED, 32'd7);
    wait_for_drain();

    // Limit below the current count: stored values stay, new adds are refused.
    write_limit(5'd2);
    send_request(bst_pkg::MODE_ADD, 32'd99);
    send_request(bst_pkg::MODE_ADD, ALL_ONES);
    send_request(bst_pkg::MODE_DELETE, 32'd0);
    send_request(bst_pkg::MODE_CHECK, MOST_POS);
    wait_for_drain();

    write_limit(5'd0);
    send_request(bst_pkg::MODE_ADD, 32'd5);
    send_request(bst_pkg::MODE_DELETE, MOST_POS);
    send_request(bst_pkg::MODE_DELETE, ALL_ONES);
    send_request(bst_pkg::MODE_DELETE, 32'd5);
    wait_for_drain();

    phase_limits = '{5'd31, 5'd16, 5'd5, 5'd1, 5'd17, 5'd0, 5'd31, 5'd3, 5'd12, 5'd16};
    phase_limits[8] = LIMIT_W'($urandom_range(0, 31));

    for (int phase = 0; phase < 10; phase++) begin
      wait_for_drain();
      write_limit(phase_limits[phase]);
      tx_steady = (phase % 3 == 1);
      rx_steady = (phase % 3 == 1);
      add_weight = $urandom_range(30, 55);
      value_pool[0] = MOST_NEG;
      value_pool[1] = MOST_POS;
      value_pool[2] = 32'd0;
      value_pool[3] = ALL_ONES;
      for (int i = 4; i < 24; i++) value_pool[i] = $urandom;
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (phase == 4 && n == PHASE_REQUESTS / 2) wait_for_drain();
        r = $urandom_range(0, 99);
        if (r < add_weight) mode = bst_pkg::MODE_ADD;
        else if (r < add_weight + 25) mode = bst_pkg::MODE_DELETE;
        else if (r < 97) mode = bst_pkg::MODE_CHECK;
        else mode = MODE_UNUSED;
        if ($urandom_range(0, 99) < 85) value = value_pool[$urandom_range(0, 23)];
        else value = $urandom;
        send_request(mode, value);
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d limit settings; largest set held %0d values.",
             requests_sent, limit_settings, sb.peak_count);
    $display("Responses seen: done %0d, present %0d, full %0d, empty %0d, missing %0d.",
             sb.status_tally[0], sb.status_tally[1], sb.status_tally[2],
             sb.status_tally[3], sb.status_tally[4]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS bounded_set_table");
    end else begin
      $display("%0d mismatches, %0d responses outstanding", sb.mismatches, sb.pending());
      $display("FAIL bounded_set_table");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bst_pkg.sv
hdl/bst_if.sv
hdl/bst_ram.sv
hdl/bounded_set_table.sv
hdl/bst_checker.sv
test/testbench.sv
